// File: hdl/bsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared types and constants of the BMP stream parser.
// ----------------------------------------------------------------------------
package bsp_pkg;

  localparam int unsigned HdrBytes = 54;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned DimW     = 16;

  // header byte offsets of the fields that are assembled
  localparam logic [IdxW-1:0] WidthOfs0  = IdxW'(18);
  localparam logic [IdxW-1:0] WidthOfs1  = IdxW'(19);
  localparam logic [IdxW-1:0] WidthOfs2  = IdxW'(20);
  localparam logic [IdxW-1:0] WidthOfs3  = IdxW'(21);
  localparam logic [IdxW-1:0] HeightOfs0 = IdxW'(22);
  localparam logic [IdxW-1:0] HeightOfs1 = IdxW'(23);
  localparam logic [IdxW-1:0] HeightOfs2 = IdxW'(24);
  localparam logic [IdxW-1:0] HeightOfs3 = IdxW'(25);
  localparam logic [IdxW-1:0] DepthOfs0  = IdxW'(28);
  localparam logic [IdxW-1:0] DepthOfs1  = IdxW'(29);
  localparam logic [IdxW-1:0] HdrLast    = IdxW'(HdrBytes - 1);
  localparam logic [IdxW-1:0] HdrDone    = IdxW'(HdrBytes);

  localparam logic [15:0] DepthFull   = 16'd32;
  localparam logic [7:0]  AlphaOpaque = 8'hFF;

  // result queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic {
    KindHeader = 1'b0,
    KindPixel  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    StatFull     = 2'd0,
    StatRgb      = 2'd1,
    StatTooLarge = 2'd2
  } status_e;

  typedef struct packed {
    kind_e            kind;
    logic [31:0]      bgra;
    logic [DimW-1:0]  row;
    logic [DimW-1:0]  col;
    logic [DimW-1:0]  width;
    logic [DimW-1:0]  height;
    logic [15:0]      depth;
    logic             too_large;
    logic             last;
  } rec_t;

endpackage

// File: hdl/bsp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_front
// Byte parser: walks the header, assembles pixels, skips row padding and
// pushes one record per result into the queue.
// ----------------------------------------------------------------------------
module bsp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    data_byte_i,
  input  logic          start_file_i,
  output logic          push_o,
  output bsp_pkg::rec_t rec_o
);
  import bsp_pkg::*;

  logic [IdxW-1:0] hdr_idx_q, hdr_idx_d;
  logic            phase_q, phase_d;
  logic [DimW-1:0] width_q, width_d, height_q, height_d;
  logic            wide_q, wide_d, tall_q, tall_d;
  logic [15:0]     depth_q, depth_d;
  logic [1:0]      bip_q, bip_d;
  logic [23:0]     accum_q, accum_d;
  logic [DimW-1:0] col_q, col_d, row_q, row_d;
  logic [1:0]      pad_q, pad_d;

  logic [IdxW-1:0] idx;
  logic            phase;
  logic            emit;
  logic            col_end, row_end, last;
  logic            byte_nz;
  rec_t            rec;

  assign byte_nz = (data_byte_i != 8'd0);

  always_comb begin
    idx      = start_file_i ? '0 : hdr_idx_q;
    phase    = start_file_i ? 1'b0 : phase_q;
    hdr_idx_d = idx;
    phase_d  = phase;
    width_d  = start_file_i ? '0 : width_q;
    height_d = start_file_i ? '0 : height_q;
    wide_d   = start_file_i ? 1'b0 : wide_q;
    tall_d   = start_file_i ? 1'b0 : tall_q;
    depth_d  = start_file_i ? '0 : depth_q;
    bip_d    = bip_q;
    accum_d  = accum_q;
    col_d    = col_q;
    row_d    = row_q;
    pad_d    = pad_q;
    emit     = 1'b0;
    col_end  = (col_q == width_q - DimW'(1));
    row_end  = (row_q == height_q - DimW'(1));
    last     = 1'b0;

    rec           = '0;
    rec.width     = width_q;
    rec.height    = height_q;
    rec.depth     = depth_q;
    rec.too_large = wide_q | tall_q;

    if (!phase) begin
      if (idx != HdrDone) begin
        case (idx)
          WidthOfs0:  width_d[7:0]   = data_byte_i;
          WidthOfs1:  width_d[15:8]  = data_byte_i;
          WidthOfs2:  wide_d         = byte_nz;
          WidthOfs3:  wide_d         = wide_q | byte_nz;
          HeightOfs0: height_d[7:0]  = data_byte_i;
          HeightOfs1: height_d[15:8] = data_byte_i;
          HeightOfs2: tall_d         = byte_nz;
          HeightOfs3: tall_d         = tall_q | byte_nz;
          DepthOfs0:  depth_d[7:0]   = data_byte_i;
          DepthOfs1:  depth_d[15:8]  = data_byte_i;
          default: ;
        endcase
        hdr_idx_d = idx + IdxW'(1);
        // the final header byte never touches a field, so the stored values are complete
        if (idx == HdrLast) begin
          emit     = 1'b1;
          rec.kind = KindHeader;
          last     = wide_q | tall_q | (width_q == '0) | (height_q == '0);
          if (!last) begin
            phase_d = 1'b1;
            bip_d   = '0;
            accum_d = '0;
            col_d   = '0;
            row_d   = '0;
            pad_d   = '0;
          end
        end
      end
    end else if (pad_q != 2'd0) begin
      pad_d = pad_q - 2'd1;
    end else begin
      if (bip_q == 2'd3) begin
        emit     = 1'b1;
        rec.bgra = {data_byte_i, accum_q};
      end else begin
        case (bip_q)
          2'd0:    accum_d[7:0]   = data_byte_i;
          2'd1:    accum_d[15:8]  = data_byte_i;
          default: accum_d[23:16] = data_byte_i;
        endcase
        bip_d = bip_q + 2'd1;
        if ((bip_q == 2'd2) && (depth_q != DepthFull)) begin
          emit     = 1'b1;
          rec.bgra = {AlphaOpaque, data_byte_i, accum_q[15:0]};
        end
      end
      if (emit) begin
        rec.kind = KindPixel;
        rec.row  = row_q;
        rec.col  = col_q;
        last     = col_end & row_end;
        bip_d    = '0;
        accum_d  = '0;
        if (col_end) begin
          col_d = '0;
          row_d = row_q + DimW'(1);
          pad_d = (depth_q != DepthFull) ? width_q[1:0] : 2'd0;
        end else begin
          col_d = col_q + DimW'(1);
        end
        if (last) begin
          phase_d = 1'b0;
          pad_d   = '0;
        end
      end
    end
    rec.last = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_idx_q <= '0;
      phase_q   <= 1'b0;
      width_q   <= '0;
      height_q  <= '0;
      wide_q    <= 1'b0;
      tall_q    <= 1'b0;
      depth_q   <= '0;
      bip_q     <= '0;
      accum_q   <= '0;
      col_q     <= '0;
      row_q     <= '0;
      pad_q     <= '0;
    end else if (accept_i) begin
      hdr_idx_q <= hdr_idx_d;
      phase_q   <= phase_d;
      width_q   <= width_d;
      height_q  <= height_d;
      wide_q    <= wide_d;
      tall_q    <= tall_d;
      depth_q   <= depth_d;
      bip_q     <= bip_d;
      accum_q   <= accum_d;
      col_q     <= col_d;
      row_q     <= row_d;
      pad_q     <= pad_d;
    end
  end

  assign push_o = accept_i & emit;
  assign rec_o  = rec;

endmodule

// File: hdl/bsp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_queue
// Short register queue of result records between parser and output stage.
// ----------------------------------------------------------------------------
module bsp_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  bsp_pkg::rec_t           rec_i,
  input  logic                    pop_i,
  output logic                    nempty_o,
  output logic                    full_o,
  output logic [bsp_pkg::QCntW-1:0] count_o,
  output bsp_pkg::rec_t           rec_o
);
  import bsp_pkg::*;

  rec_t             slot_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & nempty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= rec_i;
    end
  end

  assign nempty_o = (cnt_q != '0);
  assign full_o   = (cnt_q == QCntW'(QDepth));
  assign count_o  = cnt_q;
  assign rec_o    = slot_q[rd_ptr_q];

endmodule

// File: hdl/bsp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_back
// Output stage: takes records from the queue, derives the status code and
// holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module bsp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_nempty_i,
  input  bsp_pkg::rec_t q_rec_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bsp_pkg::rec_t rec_o,
  output logic [1:0]    status_o
);
  import bsp_pkg::*;

  logic    valid_q;
  rec_t    rec_q;
  status_e status_q, status_d;

  always_comb begin
    if (q_rec_i.too_large) begin
      status_d = StatTooLarge;
    end else if (q_rec_i.depth == DepthFull) begin
      status_d = StatFull;
    end else begin
      status_d = StatRgb;
    end
  end

  // load when the register is empty or its result is being taken
  assign q_pop_o = q_nempty_i & (~valid_q | out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_ready_i) begin
      valid_q <= q_nempty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      rec_q    <= q_rec_i;
      status_q <= status_d;
    end
  end

  assign out_valid_o = valid_q;
  assign rec_o       = rec_q;
  assign status_o    = status_q;

endmodule

// File: hdl/bmp_stream_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_stream_parser_top
// BMP byte stream parser for 24 and 32 bits per pixel.
// ----------------------------------------------------------------------------
// Input channel: one file byte per transfer, start_file_i marks byte 0 of a
// new file and drops any image in progress. After reset the parser already
// waits for header byte 0.
// Output channel: one header result after the 54th header byte, then one
// pixel result per assembled pixel (bottom row first), last one marked.
// Bytes after an image, and row padding, produce no result.
// Throughput: one byte per cycle while in_ready_o is high.
// A result passes from the parser into a two-entry queue and from the queue
// into the output register, where the receiver takes it.
// When the receiver stalls, the output register holds its result and the
// queue fills; in_ready_o drops only with the queue full, so the input keeps
// flowing as long as no more than two results are waiting.
// Reset clears the parser, the queue and the output valid.
// ----------------------------------------------------------------------------
module bmp_stream_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_file_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        item_kind_o,
  output logic [31:0] pixel_bgra_o,
  output logic [15:0] pixel_row_o,
  output logic [15:0] pixel_col_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o,
  output logic [15:0] depth_bits_o,
  output logic [1:0]  status_o,
  output logic        last_of_image_o
);
  import bsp_pkg::*;

  logic             accept;
  logic             push, pop, q_nempty, q_full;
  logic [QCntW-1:0] q_count;
  rec_t             push_rec, q_rec, out_rec;

  assign in_ready_o = ~q_full;
  assign accept     = in_valid_i & in_ready_o;

  bsp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .start_file_i (start_file_i),
    .push_o       (push),
    .rec_o        (push_rec)
  );

  bsp_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .rec_i    (push_rec),
    .pop_i    (pop),
    .nempty_o (q_nempty),
    .full_o   (q_full),
    .count_o  (q_count),
    .rec_o    (q_rec)
  );

  bsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_nempty_i  (q_nempty),
    .q_rec_i     (q_rec),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rec_o       (out_rec),
    .status_o    (status_o)
  );

  assign item_kind_o     = out_rec.kind;
  assign pixel_bgra_o    = out_rec.bgra;
  assign pixel_row_o     = out_rec.row;
  assign pixel_col_o     = out_rec.col;
  assign image_width_o   = out_rec.width;
  assign image_height_o  = out_rec.height;
  assign depth_bits_o    = out_rec.depth;
  assign last_of_image_o = out_rec.last;

  // a result is never pushed into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_full)
    else $error("result pushed into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_count <= QCntW'(QDepth))
    else $error("queue count out of range");

  // pixels only follow a header that fits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && item_kind_o == KindPixel) |-> (status_o != StatTooLarge))
    else $error("pixel result with oversized image");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && item_kind_o == KindPixel) |->
      (pixel_col_o < image_width_o && pixel_row_o < image_height_o))
    else $error("pixel position outside image");

endmodule

// File: test/bmp_stream_parser_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_stream_parser_top_test
// Self-checking bench for the BMP byte stream parser.
// ----------------------------------------------------------------------------
// Whole BMP files are built in the bench and sent one byte per transfer. A
// behavioral copy of the parser predicts every header and pixel result, and
// each result leaving the block is compared field by field with the oldest
// prediction. A short table of hand-picked files comes first (empty and
// oversized images, padded and unpadded rows, files dropped in mid-stream,
// bytes after an image). Random files follow, with noise and broken files
// mixed in. Both channels idle at random.
// ----------------------------------------------------------------------------
module bmp_stream_parser_top_test;

  import bsp_pkg::*;

  typedef enum logic [1:0] {
    FillRandom,
    FillZero,
    FillOnes
  } fill_e;

  // one test file: header fields, how much of it is sent, and what follows
  typedef struct packed {
    logic        sof;
    logic [31:0] width;
    logic [31:0] height;
    logic [15:0] depth;
    int          keep;       // bytes kept from the front, 0 keeps all
    int          tail;       // ignored bytes sent after the file
    fill_e       fill;
    logic        typed;      // header status and last flag given below
    status_e     exp_status;
    logic        exp_last;
  } file_case_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] bgra;
    logic [15:0] row;
    logic [15:0] col;
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] depth;
    status_e     status;
    logic        last;
  } bmp_result_t;

  localparam int NumDirected = 8;
  localparam int RandBytes   = 100;
  localparam int DrainCycles = 6;
  localparam int EndCycles   = 10;

  localparam file_case_t DirectedFiles [NumDirected] = '{
    // first file right after reset, no start marker
    '{1'b0, 32'd2, 32'd1, 16'd32, 0, 0, FillRandom, 1'b1, StatFull, 1'b0},
    // three bytes of padding per row, then bytes after the image
    '{1'b1, 32'd3, 32'd2, 16'd24, 0, 2, FillZero, 1'b1, StatRgb, 1'b0},
    // empty image
    '{1'b1, 32'd0, 32'd5, 16'd32, 0, 0, FillRandom, 1'b1, StatFull, 1'b1},
    // oversized images
    '{1'b1, 32'h10000, 32'd1, 16'd32, 0, 0, FillRandom, 1'b1, StatTooLarge, 1'b1},
    '{1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 0, 0, FillOnes, 1'b1,
      StatTooLarge, 1'b1},
    // dropped in mid-header, then dropped in mid-image
    '{1'b1, 32'd3, 32'd3, 16'd32, 24, 0, FillRandom, 1'b0, StatFull, 1'b0},
    '{1'b1, 32'd2, 32'd2, 16'd32, 62, 0, FillRandom, 1'b0, StatFull, 1'b0},
    // no marker: these bytes finish the dropped image, the rest is ignored
    '{1'b0, 32'd2, 32'd2, 16'd32, 12, 0, FillRandom, 1'b0, StatFull, 1'b0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        start_file_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        item_kind_o;
  logic [31:0] pixel_bgra_o;
  logic [15:0] pixel_row_o;
  logic [15:0] pixel_col_o;
  logic [15:0] image_width_o;
  logic [15:0] image_height_o;
  logic [15:0] depth_bits_o;
  logic [1:0]  status_o;
  logic        last_of_image_o;

  bmp_stream_parser_top DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .data_byte_i,
    .start_file_i,
    .out_valid_o,
    .out_ready_i,
    .item_kind_o,
    .pixel_bgra_o,
    .pixel_row_o,
    .pixel_col_o,
    .image_width_o,
    .image_height_o,
    .depth_bits_o,
    .status_o,
    .last_of_image_o
  );

  // parser copy
  logic [31:0] p_width;
  logic [31:0] p_height;
  logic [15:0] p_depth;
  int unsigned p_idx;
  logic        p_pixels;
  int unsigned p_lane;
  logic [23:0] p_accum;
  int unsigned p_col;
  int unsigned p_row;
  int unsigned p_pad;

  bmp_result_t expected_q [$];
  logic [8:0]  file_bytes [$];    // {start marker, byte}

  int    fail_count;
  int    n_files;
  int    n_bytes;
  int    n_predicted;
  int    n_headers;
  int    n_pixels;
  int    n_last;
  int    src_mode;
  int    sink_mode;
  int    payload_len;
  logic    typed_pending;
  status_e typed_status;
  logic    typed_last;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int idle_gap(input int mode);
    int r;
    if (mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < ((mode == 1) ? 75 : 40)) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic status_e size_status();
    if (p_width[31:DimW] != '0 || p_height[31:DimW] != '0) return StatTooLarge;
    return (p_depth == DepthFull) ? StatFull : StatRgb;
  endfunction

  function automatic void clear_parser();
    p_width  = '0;
    p_height = '0;
    p_depth  = '0;
    p_idx    = 0;
    p_pixels = 1'b0;
    p_lane   = 0;
    p_accum  = '0;
    p_col    = 0;
    p_row    = 0;
    p_pad    = 0;
  endfunction

  // advances the parser copy by one byte, returns 1 with a result in res
  function automatic logic parse_byte(input logic [7:0] b, input logic sof,
                                      output bmp_result_t res);
    int unsigned bpp;
    logic [7:0]  alpha;
    logic        done;
    if (sof) clear_parser();
    res = '0;
    if (!p_pixels) begin
      if (p_idx >= HdrBytes) return 1'b0;
      if (p_idx >= WidthOfs0 && p_idx <= WidthOfs3)
        p_width[8*(p_idx - WidthOfs0) +: 8] = b;
      else if (p_idx >= HeightOfs0 && p_idx <= HeightOfs3)
        p_height[8*(p_idx - HeightOfs0) +: 8] = b;
      else if (p_idx >= DepthOfs0 && p_idx <= DepthOfs1)
        p_depth[8*(p_idx - DepthOfs0) +: 8] = b;
      p_idx++;
      if (p_idx != HdrBytes) return 1'b0;
      done = (size_status() == StatTooLarge) || p_width == 0 || p_height == 0;
      res.kind = KindHeader;
      res.last = done;
      if (!done) begin
        p_pixels = 1'b1;
        p_lane   = 0;
        p_accum  = '0;
        p_col    = 0;
        p_row    = 0;
        p_pad    = 0;
      end
    end else begin
      if (p_pad != 0) begin
        p_pad--;
        return 1'b0;
      end
      bpp = (p_depth == DepthFull) ? 4 : 3;
      if (p_lane < 3) begin
        p_accum[8*p_lane +: 8] = b;
        p_lane++;
        if (p_lane < bpp) return 1'b0;
        alpha = AlphaOpaque;
      end else begin
        alpha = b;
      end
      res.kind = KindPixel;
      res.bgra = {alpha, p_accum};
      res.row  = p_row[15:0];
      res.col  = p_col[15:0];
      done = (p_col + 1 == p_width) && (p_row + 1 == p_height);
      res.last = done;
      p_lane  = 0;
      p_accum = '0;
      p_col++;
      if (p_col >= p_width) begin
        p_col = 0;
        p_row++;
        p_pad = (bpp == 3) ? p_width[1:0] : 0;
      end
      if (done) begin
        p_pixels = 1'b0;
        p_pad    = 0;
      end
    end
    res.width  = p_width[15:0];
    res.height = p_height[15:0];
    res.depth  = p_depth;
    res.status = size_status();
    return 1'b1;
  endfunction

  function automatic void build_file(input file_case_t fc);
    logic [7:0]  hdr [HdrBytes];
    logic [7:0]  b;
    int unsigned bpp;
    file_bytes.delete();
    for (int i = 0; i < HdrBytes; i++) hdr[i] = 8'($urandom);
    hdr[0] = 8'h42;   // "BM"
    hdr[1] = 8'h4D;
    for (int i = 0; i < 4; i++) begin
      hdr[WidthOfs0 + i]  = fc.width[8*i +: 8];
      hdr[HeightOfs0 + i] = fc.height[8*i +: 8];
    end
    hdr[DepthOfs0] = fc.depth[7:0];
    hdr[DepthOfs1] = fc.depth[15:8];
    for (int i = 0; i < HdrBytes; i++)
      file_bytes.insert(file_bytes.size(), {(i == 0) && fc.sof, hdr[i]});
    // pixel data only for small images
    if (fc.width != 0 && fc.height != 0 && fc.width[31:DimW] == '0 &&
        fc.height[31:DimW] == '0 && fc.width * fc.height <= 64) begin
      bpp = (fc.depth == DepthFull) ? 4 : 3;
      for (int r = 0; r < fc.height; r++) begin
        for (int k = 0; k < fc.width * bpp; k++) begin
          case (fc.fill)
            FillZero: b = 8'h00;
            FillOnes: b = 8'hFF;
            default:  b = 8'($urandom);
          endcase
          file_bytes.insert(file_bytes.size(), {1'b0, b});
        end
        if (bpp == 3)
          for (int k = 0; k < fc.width[1:0]; k++)
            file_bytes.insert(file_bytes.size(), {1'b0, 8'($urandom)});
      end
    end
    if (fc.keep != 0)
      while (file_bytes.size() > fc.keep) void'(file_bytes.pop_back());
    payload_len = file_bytes.size();
    for (int i = 0; i < fc.tail; i++)
      file_bytes.insert(file_bytes.size(), {1'b0, 8'($urandom)});
  endfunction

  task automatic push_byte(input logic [8:0] item);
    int          gap;
    bmp_result_t res;
    gap = idle_gap(src_mode);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= item[7:0];
    start_file_i <= item[8];
    do @(posedge clk_i); while (!in_ready_o);
    n_bytes++;
    if (parse_byte(item[7:0], item[8], res)) begin
      expected_q.insert(expected_q.size(), res);
      n_predicted++;
      if (res.kind == KindHeader && typed_pending) begin
        typed_pending = 1'b0;
        check_field("header status", typed_status, res.status);
        check_field("header last_of_image", typed_last, res.last);
      end
    end
  endtask

  // hold the input off until every predicted result has left the block
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_file(input file_case_t fc);
    build_file(fc);
    typed_pending = fc.typed && fc.keep == 0;
    typed_status  = fc.exp_status;
    typed_last    = fc.exp_last;
    src_mode  = $urandom_range(0, 2);
    sink_mode = $urandom_range(0, 2);
    foreach (file_bytes[i]) push_byte(file_bytes[i]);
    n_files++;
  endtask

  always @(posedge clk_i) begin : result_check
    bmp_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("result with no expectation waiting");
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("item_kind", want.kind, item_kind_o);
        check_field("pixel_bgra", want.bgra, pixel_bgra_o);
        check_field("pixel_row", want.row, pixel_row_o);
        check_field("pixel_col", want.col, pixel_col_o);
        check_field("image_width", want.width, image_width_o);
        check_field("image_height", want.height, image_height_o);
        check_field("depth_bits", want.depth, depth_bits_o);
        check_field("status", want.status, status_o);
        check_field("last_of_image", want.last, last_of_image_o);
        if (want.kind == KindHeader) n_headers++;
        else n_pixels++;
        if (want.last) n_last++;
      end
    end
  end

  initial begin : result_sink
    int stall;
    stall = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        stall = idle_gap(sink_mode);
      end
    end
  end

  initial begin : run_limit
    #(20_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    file_case_t fc;
    int         rand_bytes;
    int         junk;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    data_byte_i   = '0;
    start_file_i  = 1'b0;
    fail_count    = 0;
    n_files       = 0;
    n_bytes       = 0;
    n_predicted   = 0;
    n_headers     = 0;
    n_pixels      = 0;
    n_last        = 0;
    src_mode      = 0;
    sink_mode     = 0;
    typed_pending = 1'b0;
    typed_status  = StatFull;
    typed_last    = 1'b0;
    clear_parser();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < NumDirected; i++) run_file(DirectedFiles[i]);
    drain();

    rand_bytes = 0;
    while (rand_bytes < RandBytes) begin
      // noise with stray start markers ahead of some files
      if ($urandom_range(0, 9) == 0) begin
        junk = $urandom_range(1, 6);
        for (int k = 0; k < junk; k++)
          push_byte({$urandom_range(0, 3) == 0, 8'($urandom)});
      end
      fc = '0;
      fc.sof = $urandom_range(0, 19) != 0;
      case ($urandom_range(0, 19))
        0: begin
          fc.width  = ($urandom_range(0, 1) != 0) ? ($urandom | 32'h10000) : 32'd2;
          fc.height = fc.width[31:DimW] != '0 ? 32'($urandom_range(0, 3))
                                              : ($urandom | 32'h10000);
        end
        1: begin
          fc.width  = ($urandom_range(0, 1) != 0) ? 32'd0 : 32'($urandom_range(1, 5));
          fc.height = (fc.width == 0) ? 32'($urandom_range(0, 9)) : 32'd0;
        end
        default: begin
          fc.width  = $urandom_range(1, 6);
          fc.height = $urandom_range(1, 4);
        end
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: fc.depth = DepthFull;
        9:             fc.depth = 16'($urandom);
        default:       fc.depth = 16'd24;
      endcase
      fc.keep = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 120) : 0;
      fc.tail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      fc.fill = ($urandom_range(0, 5) == 0) ? fill_e'($urandom_range(1, 2)) : FillRandom;
      run_file(fc);
      rand_bytes += payload_len;
      if ($urandom_range(0, 4) == 0) drain();
    end

    src_mode  = 0;
    sink_mode = 0;
    drain();
    repeat (EndCycles) @(posedge clk_i);

    $display("covered %0d files in %0d bytes, %0d results: %0d header and %0d pixel",
             n_files, n_bytes, n_predicted, n_headers, n_pixels);
    $display("%0d images closed by a marked result, %0d mismatches", n_last, fail_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
